@@ sv/mle_pkg.sv @@
// Shared types, constants and the exponential table generator for the mu-law expander.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mle_pkg;

    // Default values of the top-level parameters.
    localparam int unsigned SAMPLE_BITS_DEF = 24;
    localparam int unsigned EXP_DEPTH_DEF   = 256;

    // Configuration port.
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned WET_W      = 17;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
    localparam logic [WET_W-1:0]  WET_RESET  = 17'd65536;
    localparam logic [WET_W-1:0]  WET_UNITY  = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN = 2'd0,
        REG_WET  = 2'd1
    } mle_reg_t;

    // Register values handed to each channel datapath.
    typedef struct packed {
        logic [WET_W-1:0]  wet;
        logic [GAIN_W-1:0] gain;
    } mle_cfg_t;

    // Number of register stages in one channel datapath.
    localparam int unsigned NSTG = 9;

    // Table entries are unsigned Q9.24 and reach exactly 256.0.
    localparam int unsigned TAB_W = 33;
    // Table value minus 1.0, always below 255.0 in Q8.24 plus one LSB.
    localparam int unsigned NUM_W = 32;

    localparam logic [63:0] LN2_Q30 = 64'd744261118;

    // 2^(t / 2^30) as a 13-term series of e^y in Q30, rounded to Q24 and scaled by 2^k.
    function automatic logic [TAB_W-1:0] exp2_q24(input logic [63:0] t, input int unsigned k);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        y    = (t * LN2_Q30) >> 30;
        term = 64'd1 << 30;
        sum  = term;
        term = ((term * y) >> 30) / 64'd1;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd2;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd3;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd4;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd5;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd6;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd7;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd8;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd9;  sum = sum + term;
        term = ((term * y) >> 30) / 64'd10; sum = sum + term;
        term = ((term * y) >> 30) / 64'd11; sum = sum + term;
        term = ((term * y) >> 30) / 64'd12; sum = sum + term;
        return TAB_W'(((sum + 64'd32) >> 6) << k);
    endfunction

endpackage

`default_nettype wire

@@ sv/mle_chan.sv @@
// One channel of the expander: gain, clamp, table expansion, divide by 255 and wet/dry mix.
// Nine register stages, each loaded by its own enable. Uses mle_pkg.
`default_nettype none

module mle_chan
    import mle_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic [NSTG-1:0]               ce,
    input  wire mle_cfg_t                      cfg,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0]      result
);

    localparam int unsigned SB    = SAMPLE_BITS;
    localparam int unsigned F     = SAMPLE_BITS - 1;
    localparam int unsigned IDX_W = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int unsigned POS_W = F + IDX_W + 1;
    localparam int unsigned NS_W  = NUM_W + F + 1;
    localparam int unsigned MW    = SAMPLE_BITS + 7;
    localparam int unsigned RW    = SAMPLE_BITS;
    localparam int unsigned GP_W  = SAMPLE_BITS + GAIN_W;
    localparam int unsigned IP_W  = TAB_W + F;
    localparam int unsigned D_W   = SAMPLE_BITS + 2;
    localparam int unsigned PW_W  = SAMPLE_BITS + 20;
    localparam int unsigned SUM_W = SAMPLE_BITS + 21;

    localparam logic [SB+2:0]      UNIT_P    = {{3{1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic [SB-1:0]      UNIT      = {1'b1, {F{1'b0}}};
    localparam logic [IDX_W-1:0]   DEPTH_IDX = IDX_W'(EXP_TABLE_DEPTH);
    localparam logic [POS_W-1:0]   DEPTH_POS = POS_W'(EXP_TABLE_DEPTH);
    localparam logic [TAB_W-1:0]   Q24_ONE   = TAB_W'(64'd1 << 24);
    localparam logic [NS_W-1:0]    HALF_DEN  = NS_W'(64'd255 << 23);
    localparam logic [RW-1:0]      RECIP     = RW'((64'd1 << MW) / 64'd255);
    localparam logic [MW-1:0]      DIV_CONST = MW'(255);
    localparam logic [GP_W:0]      GAIN_RND  = (GP_W+1)'(8192);
    localparam logic signed [SUM_W-1:0] MIX_RND = SUM_W'(32'sd32768);
    localparam logic signed [SUM_W-1:0] RES_MAX = {{22{1'b0}}, {F{1'b1}}};
    localparam logic signed [SUM_W-1:0] RES_MIN = {{22{1'b1}}, {F{1'b0}}};

    // Constant table of 256^(i/D) in Q9.24, built at elaboration.
    logic [TAB_W-1:0] exp_tab [EXP_TABLE_DEPTH+1];

    for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++)
    begin : g_tab
        localparam int unsigned E8 = 8 * g;
        localparam int unsigned KK = E8 / EXP_TABLE_DEPTH;
        localparam logic [63:0] RR = 64'(E8 % EXP_TABLE_DEPTH);
        localparam logic [63:0] TT = (RR << 30) / 64'(EXP_TABLE_DEPTH);
        assign exp_tab[g] = exp2_q24(TT, KK);
    end

    // Stage 1: magnitude times gain.
    logic signed [SB-1:0] x1_reg;
    logic                 neg1_reg, neg1_next;
    logic [GP_W-1:0]      prodg1_reg, prodg1_next;
    logic [SB-1:0]        mag0;

    always_comb
    begin
        neg1_next   = sample[SB-1];
        mag0        = neg1_next ? (~sample + 1'b1) : sample;
        prodg1_next = GP_W'(mag0) * GP_W'(cfg.gain);
    end

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            x1_reg     <= sample;
            neg1_reg   <= neg1_next;
            prodg1_reg <= prodg1_next;
        end
    end

    // Stage 2: round, clamp to 1.0, locate the table segment.
    logic signed [SB-1:0] x2_reg;
    logic                 neg2_reg;
    logic [IDX_W-1:0]     idx2_reg, idx2_next;
    logic [F-1:0]         fr2_reg, fr2_next;
    logic [GP_W:0]        prnd;
    logic [SB+2:0]        p_full;
    logic [SB-1:0]        p_clamp;
    logic [POS_W-1:0]     pos;

    always_comb
    begin
        prnd      = {1'b0, prodg1_reg} + GAIN_RND;
        p_full    = prnd[GP_W:14];
        p_clamp   = (p_full > UNIT_P) ? UNIT : p_full[SB-1:0];
        pos       = POS_W'(p_clamp) * DEPTH_POS;
        idx2_next = pos[F +: IDX_W];
        fr2_next  = pos[F-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            x2_reg   <= x1_reg;
            neg2_reg <= neg1_reg;
            idx2_reg <= idx2_next;
            fr2_reg  <= fr2_next;
        end
    end

    // Stage 3: table lookup. At the last entry the slope is zero.
    logic signed [SB-1:0] x3_reg;
    logic                 neg3_reg;
    logic [F-1:0]         fr3_reg;
    logic [TAB_W-1:0]     lo3_reg, lo3_next;
    logic [TAB_W-1:0]     diff3_reg, diff3_next;
    logic [IDX_W-1:0]     hi_idx;

    always_comb
    begin
        hi_idx     = (idx2_reg == DEPTH_IDX) ? idx2_reg : IDX_W'(idx2_reg + 1'b1);
        lo3_next   = exp_tab[idx2_reg];
        diff3_next = exp_tab[hi_idx] - lo3_next;
    end

    always_ff @(posedge clk)
    begin
        if (ce[2])
        begin
            x3_reg    <= x2_reg;
            neg3_reg  <= neg2_reg;
            fr3_reg   <= fr2_reg;
            lo3_reg   <= lo3_next;
            diff3_reg <= diff3_next;
        end
    end

    // Stage 4: interpolation product.
    logic signed [SB-1:0] x4_reg;
    logic                 neg4_reg;
    logic [TAB_W-1:0]     lo4_reg;
    logic [IP_W-1:0]      ipp4_reg, ipp4_next;

    always_comb
    begin
        ipp4_next = IP_W'(diff3_reg) * IP_W'(fr3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ce[3])
        begin
            x4_reg   <= x3_reg;
            neg4_reg <= neg3_reg;
            lo4_reg  <= lo3_reg;
            ipp4_reg <= ipp4_next;
        end
    end

    // Stage 5: subtract 1.0, scale to the sample format and pre-round.
    // The rounded quotient by 255*2^24 is floor(floor(n / 2^24) / 255).
    logic signed [SB-1:0] x5_reg;
    logic                 neg5_reg;
    logic [MW-1:0]        m5_reg, m5_next;
    logic [TAB_W-1:0]     v_int;
    logic [NUM_W-1:0]     num;
    logic [NS_W-1:0]      nsum;

    always_comb
    begin
        v_int   = lo4_reg + TAB_W'(ipp4_reg >> F);
        num     = NUM_W'(v_int - Q24_ONE);
        nsum    = (NS_W'(num) << F) + HALF_DEN;
        m5_next = nsum[24 +: MW];
    end

    always_ff @(posedge clk)
    begin
        if (ce[4])
        begin
            x5_reg   <= x4_reg;
            neg5_reg <= neg4_reg;
            m5_reg   <= m5_next;
        end
    end

    // Stage 6: quotient estimate by reciprocal, low by at most one.
    logic signed [SB-1:0] x6_reg;
    logic                 neg6_reg;
    logic [MW-1:0]        m6_reg;
    logic [RW-1:0]        q6_reg, q6_next;
    logic [MW+RW-1:0]     qprod;

    always_comb
    begin
        qprod   = (MW+RW)'(m5_reg) * (MW+RW)'(RECIP);
        q6_next = qprod[MW +: RW];
    end

    always_ff @(posedge clk)
    begin
        if (ce[5])
        begin
            x6_reg   <= x5_reg;
            neg6_reg <= neg5_reg;
            m6_reg   <= m5_reg;
            q6_reg   <= q6_next;
        end
    end

    // Stage 7: quotient correction, sign, and wet minus dry.
    logic signed [SB-1:0]  x7_reg;
    logic signed [D_W-1:0] d7_reg, d7_next;
    logic [MW-1:0]         q255;
    logic [MW-1:0]         rem;
    logic [SB-1:0]         magn;
    logic signed [SB:0]    e7;

    always_comb
    begin
        q255    = MW'({q6_reg, 8'b0}) - MW'(q6_reg);
        rem     = m6_reg - q255;
        magn    = (rem >= DIV_CONST) ? SB'(q6_reg + 1'b1) : q6_reg;
        e7      = neg6_reg ? -$signed({1'b0, magn}) : $signed({1'b0, magn});
        d7_next = D_W'(e7) - D_W'(x6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ce[6])
        begin
            x7_reg <= x6_reg;
            d7_reg <= d7_next;
        end
    end

    // Stage 8: (wet - dry) times the clamped wet factor.
    logic signed [SB-1:0]   x8_reg;
    logic signed [PW_W-1:0] pw8_reg, pw8_next;
    logic [WET_W-1:0]       wet_c;

    always_comb
    begin
        wet_c    = (cfg.wet > WET_UNITY) ? WET_UNITY : cfg.wet;
        pw8_next = PW_W'(d7_reg) * PW_W'($signed({1'b0, wet_c}));
    end

    always_ff @(posedge clk)
    begin
        if (ce[7])
        begin
            x8_reg  <= x7_reg;
            pw8_reg <= pw8_next;
        end
    end

    // Stage 9: add the dry term, round to nearest by 2^16 and saturate.
    logic signed [SB-1:0]    res9_reg, res9_next;
    logic signed [SUM_W-1:0] msum;
    logic signed [SUM_W-1:0] mshift;

    always_comb
    begin
        msum   = (SUM_W'(x8_reg) <<< 16) + SUM_W'(pw8_reg) + MIX_RND;
        mshift = msum >>> 16;
        if (mshift > RES_MAX)
        begin
            res9_next = RES_MAX[SB-1:0];
        end
        else if (mshift < RES_MIN)
        begin
            res9_next = RES_MIN[SB-1:0];
        end
        else
        begin
            res9_next = mshift[SB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[8])
        begin
            res9_reg <= res9_next;
        end
    end

    assign result = res9_reg;

endmodule

`default_nettype wire

@@ sv/mu_law_expander_mix_top.sv @@
// Top level of the stereo continuous mu-law expander with wet/dry mix.
// Holds the configuration registers and pipeline control; uses mle_pkg and mle_chan.
//
//  Channel    Direction  Signals                                   Word contents
//  s_axis     in         tvalid, tready, tdata, tlast              left, right, frame end
//  m_axis     out        tvalid, tready, tdata, tlast              left, right, frame end
//  cfg        in         cfg_wr_en, cfg_index, cfg_data            gain (0), wet_mix (1)
//
// The block takes one stereo word per clock while the output is not stalled and returns it
// through the depth of the per-channel datapath, whose two copies run side by side.
// Every stage has its own valid bit. A stage loads when it is empty or when the stage after
// it moves, so bubbles close up and a stalled output still lets words enter until all nine
// stages are full. Reset clears the valid bits and loads gain = 1.0 and wet_mix = 1.0.
`default_nettype none

module mu_law_expander_mix_top
    import mle_pkg::*;
#(
    parameter  int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter  int unsigned EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
    localparam int unsigned DATA_W          = ((2 * SAMPLE_BITS + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // left_sample, right_sample, zero pad (from bit 0 up)
    input  wire logic [DATA_W-1:0]     s_axis_tdata,
    input  wire logic                  s_axis_tlast,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // left_result, right_result, zero pad (from bit 0 up)
    output logic [DATA_W-1:0]          m_axis_tdata,
    output logic                       m_axis_tlast,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned SB = SAMPLE_BITS;

    // Configuration registers. Writes to unknown indexes are dropped.
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [WET_W-1:0]  wet_reg, wet_next;
    mle_cfg_t          cfg;

    always_comb
    begin
        gain_next = gain_reg;
        wet_next  = wet_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GAIN: gain_next = cfg_data[GAIN_W-1:0];
                REG_WET:  wet_next  = cfg_data[WET_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            wet_reg  <= WET_RESET;
        end
        else
        begin
            gain_reg <= gain_next;
            wet_reg  <= wet_next;
        end
    end

    assign cfg.gain = gain_reg;
    assign cfg.wet  = wet_reg;

    // Stage enables ripple back from the output: a stage may load when it is empty or
    // when its contents move on in the same cycle.
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG-1:0] last_reg, last_next;
    logic [NSTG-1:0] ce;

    always_comb
    begin
        ce[NSTG-1] = !vld_reg[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            ce[k] = !vld_reg[k] || ce[k+1];
        end
    end

    always_comb
    begin
        vld_next[0]  = ce[0] ? s_axis_tvalid : vld_reg[0];
        last_next[0] = ce[0] ? s_axis_tlast  : last_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            vld_next[k]  = ce[k] ? vld_reg[k-1]  : vld_reg[k];
            last_next[k] = ce[k] ? last_reg[k-1] : last_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // The frame-end flag is payload and travels beside the valid bits.
    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
    end

    // Two identical channel datapaths.
    logic signed [SB-1:0] left_res;
    logic signed [SB-1:0] right_res;

    mle_chan #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_left (
        .clk    (clk),
        .ce     (ce),
        .cfg    (cfg),
        .sample (s_axis_tdata[SB-1:0]),
        .result (left_res)
    );

    mle_chan #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_right (
        .clk    (clk),
        .ce     (ce),
        .cfg    (cfg),
        .sample (s_axis_tdata[2*SB-1:SB]),
        .result (right_res)
    );

    assign s_axis_tready = ce[0];
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tlast  = last_reg[NSTG-1];
    assign m_axis_tdata  = DATA_W'({right_res, left_res});

`ifndef ASSERT_OFF
    // The input may only be held off when every stage carries a word.
    a_blocked_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg)
    ) else $error("input stalled while the pipeline has a free stage");

    // Words in flight change only by the words taken in and handed out.
    a_word_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(vld_reg) + int'($past(m_axis_tvalid && m_axis_tready)) ==
             $countones($past(vld_reg)) + int'($past(s_axis_tvalid && s_axis_tready)))
    ) else $error("word lost or duplicated inside the pipeline");
`endif

endmodule

`default_nettype wire

@@ sim/mu_law_expander_mix_top_tb.sv @@
// Self-checking testbench for the stereo mu-law expander with wet/dry mix.
// Needs mle_pkg and mu_law_expander_mix_top; predicts every output word in-line.
// Directed words cover the extremes and special settings; random settings and idling follow.

module mu_law_expander_mix_top_tb;
    import mle_pkg::*;

    localparam int unsigned SB     = SAMPLE_BITS_DEF;
    localparam int unsigned DEPTH  = EXP_DEPTH_DEF;
    localparam int unsigned FB     = SB - 1;
    localparam int unsigned DATA_W = ((2 * SB + 7) / 8) * 8;
    localparam longint unsigned UNIT_Q = 64'd1 << FB;

    localparam logic [SB-1:0] FULL_POS = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] FULL_NEG = {1'b1, {(SB-1){1'b0}}};

    // Register indexes that decode to nothing; writes there must leave the settings alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned CYCLE_LIMIT = 600000;

    // One stereo word as it leaves the block.
    typedef struct packed {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
        logic          last;
    } stereo_word_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // left_sample, right_sample, zero pad (from bit 0 up)
    logic [DATA_W-1:0]     s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // left_result, right_result, zero pad (from bit 0 up)
    logic [DATA_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Settings as the block should hold them, and the words still owed by the block.
    logic [GAIN_W-1:0] gain_setting;
    logic [WET_W-1:0]  wet_setting;
    stereo_word_t      pending_pairs[$];
    longint unsigned   exp_q24[0:DEPTH];

    int unsigned mismatches;
    bit          sender_idling;
    bit          receiver_idling;
    int unsigned stall_left;

    mu_law_expander_mix_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The table 256^(i/DEPTH) in Q9.24: 2^(8i/DEPTH) split into an integer power of two
    // and a fractional part evaluated as a truncated Taylor series of e^(t*ln2) in Q30.
    function automatic void fill_exp_table();
        longint unsigned octave, steps, t, y, term, acc;
        for (int i = 0; i <= DEPTH; i++)
        begin
            octave = (8 * i) / DEPTH;
            steps  = (8 * i) % DEPTH;
            t      = (steps << 30) / DEPTH;
            y      = (t * LN2_Q30) >> 30;
            term   = 64'd1 << 30;
            acc    = term;
            for (int n = 1; n <= 12; n++)
            begin
                term = ((term * y) >> 30) / n;
                acc  = acc + term;
            end
            exp_q24[i] = ((acc + 64'd32) >> 6) << octave;
        end
    endfunction

    // Gain, clamp, expand by (256^a - 1)/255 with table interpolation, then wet/dry mix.
    function automatic logic [SB-1:0] expand_and_mix(input logic [SB-1:0] raw);
        longint signed   x, e, acc;
        longint unsigned mag, p, pos, idx, fr, v, num, den, emag, w;
        bit              neg;
        x    = $signed(raw);
        neg  = x < 0;
        mag  = neg ? -x : x;
        p    = (mag * gain_setting + 64'd8192) >> 14;
        if (p > UNIT_Q)
            p = UNIT_Q;
        pos  = p * DEPTH;
        idx  = pos >> FB;
        fr   = pos & (UNIT_Q - 1);
        if (idx >= DEPTH)
            v = exp_q24[DEPTH];
        else
            v = exp_q24[idx] + (((exp_q24[idx+1] - exp_q24[idx]) * fr) >> FB);
        num  = v - (64'd1 << 24);
        den  = 64'd255 << 24;
        emag = ((num << FB) + den / 2) / den;
        e    = neg ? -longint'(emag) : longint'(emag);
        // Wet settings above unity behave as fully wet.
        w    = (wet_setting > WET_UNITY) ? 64'd65536 : wet_setting;
        acc  = e * longint'(w) + x * longint'(64'd65536 - w) + 32768;
        acc  = acc >>> 16;
        if (acc > longint'(UNIT_Q - 1))
            acc = longint'(UNIT_Q - 1);
        if (acc < -longint'(UNIT_Q))
            acc = -longint'(UNIT_Q);
        return acc[SB-1:0];
    endfunction

    task automatic note_mismatch(input string field, input logic [SB-1:0] want,
                                 input logic [SB-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch in %s: expected %0d, got %0d", field, $signed(want), $signed(got));
    endtask

    // Scoreboard. Every accepted input word queues its prediction, and every accepted output
    // word is checked against the oldest one. Both are sampled at the rising edge, before
    // the block's own registers update.
    always @(posedge clk)
    begin : scoreboard
        stereo_word_t want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            want.left  = expand_and_mix(s_axis_tdata[SB-1:0]);
            want.right = expand_and_mix(s_axis_tdata[2*SB-1:SB]);
            want.last  = s_axis_tlast;
            pending_pairs.push_back(want);
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_pairs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected output word: left %0d right %0d last %0b",
                             $signed(m_axis_tdata[SB-1:0]), $signed(m_axis_tdata[2*SB-1:SB]),
                             m_axis_tlast);
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (m_axis_tdata[SB-1:0] !== want.left)
                    note_mismatch("left_result", want.left, m_axis_tdata[SB-1:0]);
                if (m_axis_tdata[2*SB-1:SB] !== want.right)
                    note_mismatch("right_result", want.right, m_axis_tdata[2*SB-1:SB]);
                if (m_axis_tlast !== want.last)
                    note_mismatch("frame_end_out", SB'(want.last), SB'(m_axis_tlast));
            end
        end
    end

    // Output back-pressure: while enabled, stalls come in bursts of random length.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if (receiver_idling && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // A run that hangs ends here.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("mu_law_expander_mix_top regression: fail");
        $finish;
    end

    // Sends one stereo word, called and returning at a falling edge. Valid stays high
    // on return so that back-to-back words are possible; a gap lowers it first.
    task automatic send_pair(input logic [SB-1:0] left, input logic [SB-1:0] right,
                             input logic frame_end);
        int unsigned gap;
        gap = 0;
        if (sender_idling && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 16);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'({right, left});
        s_axis_tlast  <= frame_end;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Stops the input stream and waits until the block has returned every word it owes.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        wait (pending_pairs.size() == 0);
        @(negedge clk);
    endtask

    // One write pulse on the configuration port; the model follows the same decode.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_GAIN: gain_setting = value[GAIN_W-1:0];
            REG_WET:  wet_setting  = value[WET_W-1:0];
            default:  ;
        endcase
    endtask

    // New settings are only written once the pipeline is empty.
    task automatic apply_levels(input logic [GAIN_W-1:0] gain, input logic [WET_W-1:0] wet);
        wait_drained();
        repeat (NSTG) @(negedge clk);
        // The bit above the gain field is ignored by the block, so it is driven at random.
        write_reg(REG_GAIN, {1'($urandom_range(0, 1)), gain});
        write_reg(REG_WET, wet);
    endtask

    // Mostly full-range samples, with full scale, zero and small magnitudes mixed in.
    function automatic logic [SB-1:0] draw_sample();
        logic [SB-1:0] mag;
        mag = SB'($urandom_range(0, 1 << 14));
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 4))
                    0:       return FULL_POS;
                    1:       return FULL_NEG;
                    2:       return '0;
                    3:       return '1;
                    default: return SB'(1);
                endcase
            1, 2:    return $urandom_range(0, 1) ? mag : -mag;
            default: return SB'($urandom());
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] draw_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_RESET;
            3:       return GAIN_W'($urandom_range(0, 32768));
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    function automatic logic [WET_W-1:0] draw_wet();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return WET_UNITY;
            2:       return '1;
            3:       return WET_W'($urandom_range(65537, 131071));
            default: return WET_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Reset settings (unity gain, fully wet): zero, both full scales, the most negative
    // sample whose magnitude is exactly 1.0, and the smallest magnitudes.
    task automatic test_reset_defaults();
        send_pair('0, FULL_POS, 1'b0);
        send_pair(FULL_NEG, FULL_POS, 1'b1);
        send_pair('1, SB'(1), 1'b0);
        send_pair(SB'(24'h400000), SB'(24'hC00000), 1'b0);
        send_pair(SB'(24'h0ABCDE), SB'(24'hF54321), 1'b1);
        send_pair(FULL_POS, FULL_NEG, 1'b0);
    endtask

    // Maximum gain pushes full-scale inputs to an expanded +1.0, which must saturate;
    // a wet setting above unity must act as fully wet. Then zero gain with fully dry output.
    task automatic test_gain_wet_extremes();
        apply_levels('1, '1);
        send_pair(FULL_POS, FULL_NEG, 1'b0);
        send_pair(SB'(24'h100000), SB'(24'hF00000), 1'b1);
        send_pair(SB'(1), '1, 1'b0);
        send_pair(SB'(24'h003000), SB'(24'hFFD000), 1'b0);
        apply_levels('0, '0);
        send_pair(FULL_POS, FULL_NEG, 1'b1);
        send_pair(SB'(24'h123456), SB'(24'hEDCBAA), 1'b0);
        apply_levels(GAIN_RESET, WET_W'(32768));
        send_pair(FULL_NEG, SB'(24'h200000), 1'b1);
        send_pair(SB'(24'h7FF000), SB'(24'h800800), 1'b0);
    endtask

    // Writes to indexes that hold no register must not disturb the settings.
    task automatic test_register_decode();
        apply_levels(16'd20000, WET_W'(50000));
        write_reg(REG_UNUSED_A, '1);
        write_reg(REG_UNUSED_B, CFG_DATA_W'($urandom()));
        write_reg(REG_UNUSED_A, '0);
        send_pair(FULL_POS, FULL_NEG, 1'b0);
        send_pair(SB'(24'h3A5A5A), SB'(24'hC5A5A6), 1'b1);
        send_pair(SB'(24'h000100), SB'(24'hFFFF00), 1'b0);
    endtask

    // Phases of random words under random settings, with idling on both sides.
    // The first two phases pin the setting extremes; one phase pauses mid-stream
    // until the block has drained.
    task automatic test_random_settings();
        int unsigned count;
        sender_idling   = 1'b1;
        receiver_idling = 1'b1;
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0:       apply_levels('1, '0);
                1:       apply_levels('0, '1);
                default: apply_levels(draw_gain(), draw_wet());
            endcase
            // Some phases run with one side never idling.
            sender_idling   = (phase % 4) != 2;
            receiver_idling = (phase % 5) != 3;
            count = $urandom_range(110, 150);
            for (int n = 0; n < count; n++)
            begin
                send_pair(draw_sample(), draw_sample(), $urandom_range(0, 3) == 0);
                if (phase == 4 && n == count / 2)
                    wait_drained();
            end
        end
    endtask

    // Closing stretch at full rate: no gaps and no stalls.
    task automatic test_full_rate();
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        apply_levels(draw_gain(), draw_wet());
        for (int n = 0; n < 300; n++)
            send_pair(draw_sample(), draw_sample(), $urandom_range(0, 3) == 0);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tlast    = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_GAIN;
        cfg_data        = '0;
        mismatches      = 0;
        stall_left      = 0;
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        gain_setting    = GAIN_RESET;
        wet_setting     = WET_RESET;
        fill_exp_table();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_gain_wet_extremes();
        test_register_decode();
        test_random_settings();
        test_full_rate();

        // Let the last words out, then give the block a few more cycles in case
        // it emits anything it should not.
        wait_drained();
        repeat (NSTG + 8) @(posedge clk);
        if (mismatches == 0 && pending_pairs.size() == 0)
            $display("mu_law_expander_mix_top regression: pass");
        else
            $display("mu_law_expander_mix_top regression: fail");
        $finish;
    end

endmodule
